FILE: src/coe_pkg.sv
// Package with payload types and decode constants for the opcode 0x00-0x2F executor.
package coe_pkg;

    // One instruction to execute, with its immediates and the memory byte it may load.
    typedef struct packed {
        logic [5:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } t_in_item;

    // Register file after the instruction, plus the memory write it causes.
    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  reg_a;
        logic [15:0] reg_bc;
        logic [15:0] reg_de;
        logic [15:0] reg_hl;
        logic [1:0]  write_kind;
        logic [15:0] write_address;
        logic [15:0] write_data;
    } t_out_item;

    // Memory write kinds.
    localparam logic [1:0] WK_NONE = 2'd0;
    localparam logic [1:0] WK_BYTE = 2'd1;
    localparam logic [1:0] WK_WORD = 2'd2;

    // Register pair selected by the upper opcode bits.
    localparam logic [1:0] PAIR_BC   = 2'd0;
    localparam logic [1:0] PAIR_DE   = 2'd1;
    localparam logic [1:0] PAIR_HL   = 2'd2;
    localparam logic [1:0] PAIR_NONE = 2'd3;

    // Operation selected by the low opcode nibble.
    localparam logic [3:0] NIB_LD_D16  = 4'h1;
    localparam logic [3:0] NIB_ST_A    = 4'h2;
    localparam logic [3:0] NIB_INC16   = 4'h3;
    localparam logic [3:0] NIB_INC_HI  = 4'h4;
    localparam logic [3:0] NIB_DEC_HI  = 4'h5;
    localparam logic [3:0] NIB_LD_HI   = 4'h6;
    localparam logic [3:0] NIB_ROT_L   = 4'h7;
    localparam logic [3:0] NIB_ST_SP   = 4'h8;
    localparam logic [3:0] NIB_ADD_HL  = 4'h9;
    localparam logic [3:0] NIB_LD_A    = 4'hA;
    localparam logic [3:0] NIB_DEC16   = 4'hB;
    localparam logic [3:0] NIB_INC_LO  = 4'hC;
    localparam logic [3:0] NIB_DEC_LO  = 4'hD;
    localparam logic [3:0] NIB_LD_LO   = 4'hE;
    localparam logic [3:0] NIB_ROT_R   = 4'hF;

    // Instruction lengths in bytes.
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

endpackage

FILE: src/cpu_opcode_execute_00_2f_unit.sv
// Executor for CPU opcodes 0x00 to 0x2F with input and result registers.
// A result passes from the input register through the execute logic to the result register.
// Throughput: one instruction per cycle while the result is not stalled; PC, A, BC, DE and HL
// are updated together, so each instruction sees the state left by the one before.
// A stalled result holds the execute stage; the input register still takes one more item.
// Reset (synchronous, active low) clears PC, A, BC, DE, HL, the stack pointer and both valids.
module cpu_opcode_execute_00_2f_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  coe_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output coe_pkg::t_out_item o_out_data,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);

    // Input stage.
    logic              r_in_valid;
    coe_pkg::t_in_item r_in_data;

    // Architectural state.
    logic [15:0] r_sp;
    logic [15:0] r_pc;
    logic [7:0]  r_a;
    logic [15:0] r_bc;
    logic [15:0] r_de;
    logic [15:0] r_hl;

    // Result stage.
    logic               r_out_valid;
    coe_pkg::t_out_item r_out_data;

    // Execute stage next values.
    logic        exec_fire;
    logic [1:0]  pair_sel;
    logic [3:0]  nib;
    logic [15:0] p;
    logic [15:0] imm16;
    logic [15:0] n_p;
    logic [15:0] n_pc;
    logic [7:0]  n_a;
    logic [15:0] n_bc;
    logic [15:0] n_de;
    logic [15:0] n_hl;
    logic [1:0]  len;
    logic [1:0]  wkind;
    logic [15:0] waddr;
    logic [15:0] wdata;
    logic        add_hl;

    // Handshake: the execute stage moves when its result slot is free or being drained.
    assign exec_fire   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || exec_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Field decode.
    assign pair_sel = r_in_data.opcode[5:4];
    assign nib      = r_in_data.opcode[3:0];
    assign imm16    = {r_in_data.imm_high, r_in_data.imm_low};

    // Select the register pair the instruction works on.
    always_comb begin
        unique case (pair_sel)
            coe_pkg::PAIR_BC: p = r_bc;
            coe_pkg::PAIR_DE: p = r_de;
            coe_pkg::PAIR_HL: p = r_hl;
            default:          p = r_hl;
        endcase
    end

    // Execute one instruction against the current state.
    always_comb begin
        n_p    = p;
        n_a    = r_a;
        len    = coe_pkg::LEN_ONE;
        wkind  = coe_pkg::WK_NONE;
        waddr  = 16'h0000;
        wdata  = 16'h0000;
        add_hl = 1'b0;
        if (pair_sel != coe_pkg::PAIR_NONE) begin
            unique case (nib)
                coe_pkg::NIB_LD_D16: begin
                    n_p = imm16;
                    len = coe_pkg::LEN_THREE;
                end
                coe_pkg::NIB_ST_A: begin
                    wkind = coe_pkg::WK_BYTE;
                    waddr = p;
                    wdata = {8'h00, r_a};
                    if (pair_sel == coe_pkg::PAIR_HL) begin
                        n_p = p + 16'd1;
                    end
                end
                coe_pkg::NIB_INC16:  n_p = p + 16'd1;
                coe_pkg::NIB_INC_HI: n_p = {p[15:8] + 8'd1, p[7:0]};
                coe_pkg::NIB_DEC_HI: n_p = {p[15:8] - 8'd1, p[7:0]};
                coe_pkg::NIB_LD_HI: begin
                    n_p = {r_in_data.imm_low, p[7:0]};
                    len = coe_pkg::LEN_TWO;
                end
                coe_pkg::NIB_ROT_L: begin
                    if (pair_sel == coe_pkg::PAIR_BC) begin
                        n_a = {r_a[6:0], r_a[7]};
                    end
                end
                coe_pkg::NIB_ST_SP: begin
                    if (pair_sel == coe_pkg::PAIR_BC) begin
                        wkind = coe_pkg::WK_WORD;
                        waddr = imm16;
                        wdata = r_sp;
                        len   = coe_pkg::LEN_THREE;
                    end
                end
                coe_pkg::NIB_ADD_HL: add_hl = 1'b1;
                coe_pkg::NIB_LD_A: begin
                    n_a = r_in_data.read_data;
                    if (pair_sel == coe_pkg::PAIR_HL) begin
                        n_p = p + 16'd1;
                    end
                end
                coe_pkg::NIB_DEC16:  n_p = p - 16'd1;
                coe_pkg::NIB_INC_LO: n_p = {p[15:8], p[7:0] + 8'd1};
                coe_pkg::NIB_DEC_LO: n_p = {p[15:8], p[7:0] - 8'd1};
                coe_pkg::NIB_LD_LO: begin
                    n_p = {p[15:8], r_in_data.imm_low};
                    len = coe_pkg::LEN_TWO;
                end
                coe_pkg::NIB_ROT_R: begin
                    if (pair_sel == coe_pkg::PAIR_BC) begin
                        n_a = {r_a[0], r_a[7:1]};
                    end else if (pair_sel == coe_pkg::PAIR_HL) begin
                        n_a = ~r_a;
                    end
                end
                default: n_p = p;
            endcase
        end
    end

    // Write the pair back; ADD HL then overrides HL (this also covers ADD HL,HL).
    always_comb begin
        n_bc = r_bc;
        n_de = r_de;
        n_hl = r_hl;
        if (pair_sel == coe_pkg::PAIR_BC) begin
            n_bc = n_p;
        end else if (pair_sel == coe_pkg::PAIR_DE) begin
            n_de = n_p;
        end else if (pair_sel == coe_pkg::PAIR_HL) begin
            n_hl = n_p;
        end
        if (add_hl) begin
            n_hl = r_hl + p;
        end
        n_pc = r_pc + {14'd0, len};
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Stack pointer configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= 16'h0000;
        end else if (i_cfg_wr_en) begin
            r_sp <= i_cfg_wr_data;
        end
    end

    // Architectural state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 16'h0000;
            r_a  <= 8'h00;
            r_bc <= 16'h0000;
            r_de <= 16'h0000;
            r_hl <= 16'h0000;
        end else if (exec_fire) begin
            r_pc <= n_pc;
            r_a  <= n_a;
            r_bc <= n_bc;
            r_de <= n_de;
            r_hl <= n_hl;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (exec_fire) begin
            r_out_data.next_pc       <= n_pc;
            r_out_data.reg_a         <= n_a;
            r_out_data.reg_bc        <= n_bc;
            r_out_data.reg_de        <= n_de;
            r_out_data.reg_hl        <= n_hl;
            r_out_data.write_kind    <= wkind;
            r_out_data.write_address <= waddr;
            r_out_data.write_data    <= wdata;
        end
    end

endmodule

FILE: src/coe_checker.sv
// Port-level checker for the opcode executor, bound to the top level.
module coe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input coe_pkg::t_out_item o_out_data
);

    // Program counter of the last result transfer.
    logic [15:0] r_last_pc;
    logic [15:0] pc_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pc <= 16'h0000;
        end else if (o_out_valid && i_out_ready) begin
            r_last_pc <= o_out_data.next_pc;
        end
    end

    assign pc_step = o_out_data.next_pc - r_last_pc;

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Write kind never takes the unused code.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.write_kind != 2'd3)
        else $error("illegal write kind");

    // Without a write, address and data are zero.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_kind == coe_pkg::WK_NONE
        |-> o_out_data.write_address == 16'h0000 && o_out_data.write_data == 16'h0000)
        else $error("write fields set without a write");

    // Each transferred instruction advances PC by one to three bytes over the last one.
    a_pc_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready
        |-> pc_step == 16'd1 || pc_step == 16'd2 || pc_step == 16'd3)
        else $error("program counter step out of range");

endmodule

bind cpu_opcode_execute_00_2f_unit coe_checker u_coe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
